>>> hdl/fed_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register codes, reset values and a helper of the feedback echo delay.
package fed_pkg;

	localparam int unsigned FED_SAMPLE_W = 16;
	localparam int unsigned FED_CHAN_OUT_W = 3;
	localparam int unsigned FED_NCH_W = 4;
	localparam int unsigned FED_FRAMES_W = 16;
	localparam int unsigned FED_GAIN_W = 15;
	localparam int unsigned FED_CFG_IDX_W = 2;
	localparam int unsigned FED_CFG_DATA_W = 16;

	localparam int unsigned FED_DEF_RING_DEPTH = 65536;
	localparam int unsigned FED_DEF_MAX_CHANNELS = 8;
	localparam int unsigned FED_QUEUE_DEPTH = 4;

	localparam logic [FED_NCH_W-1:0] FED_RST_NUM_CHANNELS = 4'd2;
	localparam logic [FED_FRAMES_W-1:0] FED_RST_DELAY_FRAMES = 16'd1024;
	localparam logic [FED_GAIN_W-1:0] FED_RST_FEEDBACK_GAIN = 15'd16384;

	typedef enum logic [FED_CFG_IDX_W-1:0] {
		FED_REG_NUM_CHANNELS,
		FED_REG_DELAY_FRAMES,
		FED_REG_FEEDBACK_GAIN
	} fed_reg_t;

	// Width of a channel counter for a given channel count.
	function automatic int unsigned fed_chan_w(input int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

>>> hdl/fed_queue.sv
`timescale 1ns / 1ps
// Small first-in first-out queue between the front and the back of the echo delay.
module fed_queue #(
	parameter int unsigned W = 16,
	parameter int unsigned DEPTH = fed_pkg::FED_QUEUE_DEPTH,
	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         head_valid,
	output logic [W-1:0] head_data,
	input  logic         pop
);

	logic [W-1:0] slot_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CntW'(1);
				2'b01: count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue holds more entries than its depth");

endmodule

>>> hdl/fed_front.sv
`timescale 1ns / 1ps
// Front of the echo delay: takes samples, tracks channel and frame, forms ring addresses.
module fed_front #(
	parameter int unsigned RING_DEPTH = fed_pkg::FED_DEF_RING_DEPTH,
	parameter int unsigned MAX_CHANNELS = fed_pkg::FED_DEF_MAX_CHANNELS,
	localparam int unsigned AddrW = $clog2(RING_DEPTH),
	localparam int unsigned ChW = fed_pkg::fed_chan_w(MAX_CHANNELS)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [fed_pkg::FED_NCH_W-1:0]            num_channels,
	input  logic [fed_pkg::FED_FRAMES_W-1:0]         delay_frames,
	input  logic                                     restart,
	input  logic                                     clearing,
	input  logic                                     queue_full,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [fed_pkg::FED_SAMPLE_W-1:0]  sample_in,
	output logic                                     push,
	output logic signed [fed_pkg::FED_SAMPLE_W-1:0]  push_sample,
	output logic [ChW-1:0]                           push_chan,
	output logic [AddrW-1:0]                         push_wa,
	output logic [AddrW-1:0]                         push_ra
);

	import fed_pkg::*;

	localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned LenW = $clog2(RING_DEPTH + 1);
	localparam int unsigned CmpW = (FED_FRAMES_W + CntW > LenW) ? FED_FRAMES_W + CntW : LenW;

	// Longest ring of whole frames for each channel count.
	logic [CmpW-1:0] cap_tab [MAX_CHANNELS + 1];

	assign cap_tab[0] = '0;
	for (genvar g = 1; g <= MAX_CHANNELS; g++) begin : g_cap
		localparam int unsigned CapLen = (RING_DEPTH / g) * g;
		assign cap_tab[g] = CmpW'(CapLen);
	end

	logic [4:0] nch_ext;
	logic [CntW-1:0] chans_c;
	logic [FED_FRAMES_W-1:0] frames_c;
	logic [CmpW-1:0] prod_c;
	logic [LenW-1:0] len_c;

	logic [CntW-1:0] chans_q;
	logic [LenW-1:0] len_q;
	logic settle_q;
	logic [ChW-1:0] ch_q;
	logic [AddrW-1:0] rp_q;

	logic accept;
	logic frame_end;
	logic [LenW-1:0] wbase;
	logic [LenW-1:0] rp_sum;
	logic [AddrW-1:0] rp_next;

	assign nch_ext = {1'b0, num_channels};

	always_comb begin
		if (num_channels == '0) begin
			chans_c = CntW'(1);
		end else if (nch_ext > 5'(MAX_CHANNELS)) begin
			chans_c = CntW'(MAX_CHANNELS);
		end else begin
			chans_c = CntW'(nch_ext);
		end
		frames_c = (delay_frames == '0) ? FED_FRAMES_W'(1) : delay_frames;
		prod_c = CmpW'(frames_c) * CmpW'(chans_c);
		len_c = (prod_c > cap_tab[chans_c]) ? LenW'(cap_tab[chans_c]) : LenW'(prod_c);
	end

	assign in_ready = !queue_full && !clearing && !settle_q;
	assign accept = in_valid && in_ready;

	// The write frame trails the read frame by one frame, modulo the ring length.
	assign wbase = (rp_q == '0) ? len_q - LenW'(chans_q) : LenW'(rp_q) - LenW'(chans_q);
	assign frame_end = ((CntW'(ch_q) + CntW'(1)) == chans_q);
	assign rp_sum = LenW'(rp_q) + LenW'(chans_q);
	assign rp_next = (rp_sum >= len_q) ? '0 : AddrW'(rp_sum);

	assign push = accept;
	assign push_sample = sample_in;
	assign push_chan = ch_q;
	assign push_wa = AddrW'(wbase) + AddrW'(ch_q);
	assign push_ra = rp_q + AddrW'(ch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chans_q <= CntW'(1);
			len_q <= LenW'(1);
			settle_q <= 1'b1;
			ch_q <= '0;
			rp_q <= '0;
		end else begin
			chans_q <= chans_c;
			len_q <= len_c;
			settle_q <= restart;
			if (restart) begin
				ch_q <= '0;
				rp_q <= '0;
			end else if (accept) begin
				if (frame_end) begin
					ch_q <= '0;
					rp_q <= rp_next;
				end else begin
					ch_q <= ch_q + ChW'(1);
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		CntW'(ch_q) < chans_q)
		else $error("channel position reached the channel count");

	assert property (@(posedge clk) disable iff (!arst_n)
		LenW'(rp_q) < len_q)
		else $error("read frame position outside the ring");

endmodule

>>> hdl/fed_back.sv
`timescale 1ns / 1ps
// Back of the echo delay: ring memory, clearing pass, echo arithmetic and output register.
module fed_back #(
	parameter int unsigned RING_DEPTH = fed_pkg::FED_DEF_RING_DEPTH,
	parameter int unsigned MAX_CHANNELS = fed_pkg::FED_DEF_MAX_CHANNELS,
	localparam int unsigned AddrW = $clog2(RING_DEPTH),
	localparam int unsigned ChW = fed_pkg::fed_chan_w(MAX_CHANNELS)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [fed_pkg::FED_GAIN_W-1:0]           feedback_gain,
	output logic                                     clearing,
	input  logic                                     head_valid,
	output logic                                     head_pop,
	input  logic signed [fed_pkg::FED_SAMPLE_W-1:0]  head_sample,
	input  logic [ChW-1:0]                           head_chan,
	input  logic [AddrW-1:0]                         head_wa,
	input  logic [AddrW-1:0]                         head_ra,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [fed_pkg::FED_SAMPLE_W-1:0]  sample_out,
	output logic [fed_pkg::FED_CHAN_OUT_W-1:0]       channel_index
);

	import fed_pkg::*;

	logic signed [FED_SAMPLE_W-1:0] ring_mem [RING_DEPTH];

	logic adv;
	logic clr_q;
	logic [AddrW-1:0] clr_addr_q;

	logic valid_s1;
	logic signed [FED_SAMPLE_W-1:0] sample_s1;
	logic [ChW-1:0] chan_s1;
	logic [AddrW-1:0] wa_s1;
	logic [AddrW-1:0] ra_s1;
	logic signed [FED_SAMPLE_W-1:0] rdata_s1;
	logic signed [FED_SAMPLE_W-1:0] delayed_s1;

	logic valid_s2;
	logic signed [FED_SAMPLE_W-1:0] sample_s2;
	logic [ChW-1:0] chan_s2;
	logic [AddrW-1:0] wa_s2;
	logic signed [FED_SAMPLE_W-1:0] delayed_s2;
	logic signed [31:0] prod_s2;
	logic signed [16:0] fb_s2;
	logic signed [17:0] st_full_s2;
	logic signed [FED_SAMPLE_W-1:0] store_s2;
	logic signed [16:0] mix_full_s2;
	logic signed [FED_SAMPLE_W-1:0] mix_s2;

	logic lw_valid_q;
	logic [AddrW-1:0] lw_addr_q;
	logic signed [FED_SAMPLE_W-1:0] lw_data_q;

	logic out_valid_q;
	logic signed [FED_SAMPLE_W-1:0] sample_out_q;
	logic [FED_CHAN_OUT_W-1:0] chan_out_q;

	logic mem_we;
	logic [AddrW-1:0] mem_waddr;
	logic signed [FED_SAMPLE_W-1:0] mem_wdata;

	// The whole back pipeline moves together whenever the output register can take a result.
	assign adv = !out_valid_q || out_ready;
	assign head_pop = adv && head_valid && !clr_q;
	assign clearing = clr_q;

	// The registered read misses the write made on the same edge and the one of the item
	// now in the second stage; both are forwarded by address. When the read and write
	// addresses coincide the ring is one frame long and the delayed sample is the input.
	always_comb begin
		if (ra_s1 == wa_s1) begin
			delayed_s1 = sample_s1;
		end else if (valid_s2 && (wa_s2 == ra_s1)) begin
			delayed_s1 = store_s2;
		end else if (lw_valid_q && (lw_addr_q == ra_s1)) begin
			delayed_s1 = lw_data_q;
		end else begin
			delayed_s1 = rdata_s1;
		end
	end

	always_comb begin
		prod_s2 = delayed_s2 * $signed({1'b0, feedback_gain});
		// Q0.15 scaling with the quotient truncated toward zero.
		if (prod_s2[31]) begin
			fb_s2 = 17'((prod_s2 + 32'sd32767) >>> 15);
		end else begin
			fb_s2 = 17'(prod_s2 >>> 15);
		end
		st_full_s2 = 18'(sample_s2) + 18'(fb_s2);
		if (st_full_s2 > 18'sd32767) begin
			store_s2 = 16'sd32767;
		end else if (st_full_s2 < -18'sd32768) begin
			store_s2 = -16'sd32768;
		end else begin
			store_s2 = st_full_s2[15:0];
		end
		mix_full_s2 = 17'(delayed_s2) + 17'(sample_s2);
		if (mix_full_s2 >= 17'sd32767) begin
			mix_s2 = 16'sd32766;
		end else if (mix_full_s2 <= -17'sd32768) begin
			mix_s2 = -16'sd32767;
		end else begin
			mix_s2 = mix_full_s2[15:0];
		end
	end

	assign mem_we = clr_q || (adv && valid_s2);
	assign mem_waddr = clr_q ? clr_addr_q : wa_s2;
	assign mem_wdata = clr_q ? '0 : store_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			lw_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AddrW'(1);
				if (clr_addr_q == AddrW'(RING_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (adv) begin
				valid_s1 <= head_pop;
				valid_s2 <= valid_s1;
				lw_valid_q <= valid_s2;
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= head_sample;
			chan_s1 <= head_chan;
			wa_s1 <= head_wa;
			ra_s1 <= head_ra;
			sample_s2 <= sample_s1;
			chan_s2 <= chan_s1;
			wa_s2 <= wa_s1;
			delayed_s2 <= delayed_s1;
			lw_addr_q <= wa_s2;
			lw_data_q <= store_s2;
			if (valid_s2) begin
				sample_out_q <= mix_s2;
				chan_out_q <= FED_CHAN_OUT_W'(chan_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rdata_s1 <= ring_mem[head_ra];
		end
	end

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign channel_index = chan_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!head_valid && !valid_s1 && !valid_s2))
		else $error("sample in flight while the ring is being cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> ($past(clr_addr_q) == AddrW'(RING_DEPTH - 1)))
		else $error("clearing pass ended before the last ring entry");

endmodule

>>> hdl/feedback_echo_delay_top.sv
`timescale 1ns / 1ps
// Top level of the feedback echo delay for interleaved signed 16-bit audio.
//
// Usage. Samples enter on the in_valid / in_ready channel, one signed sample per
// transaction, channels interleaved in order. Every input transaction yields exactly one
// output transaction on out_valid / out_ready: the input plus the echo read from the ring,
// saturated to -32767..32766, tagged with its channel position in the frame.
// Three registers are written over cfg_we / cfg_index / cfg_data: channel count, delay
// in frames and feedback gain in unsigned Q0.15. Any accepted register write restarts
// the frame positions; ring contents stay. Write them only while no sample is in flight.
//
// Throughput is one sample per clock while in_ready and out_ready stay high. Each sample
// uses the ring's single write port and single read port once, and a front address stage
// is decoupled from the back arithmetic by a four-entry queue. A result passes through the
// queue, the two back stages and the output register before it is offered.
// After reset, in_ready stays low while the whole ring is cleared to zero one entry per
// cycle, and in the cycle after every register write.
// When the receiver holds out_ready low the back pipeline stops, the queue fills and
// in_ready drops; no transaction is lost or repeated.
module feedback_echo_delay_top #(
	parameter int unsigned RING_DEPTH = fed_pkg::FED_DEF_RING_DEPTH,
	parameter int unsigned MAX_CHANNELS = fed_pkg::FED_DEF_MAX_CHANNELS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [fed_pkg::FED_CFG_IDX_W-1:0]        cfg_index,
	input  logic [fed_pkg::FED_CFG_DATA_W-1:0]       cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [fed_pkg::FED_SAMPLE_W-1:0]  sample_in,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [fed_pkg::FED_SAMPLE_W-1:0]  sample_out,
	output logic [fed_pkg::FED_CHAN_OUT_W-1:0]       channel_index
);

	import fed_pkg::*;

	localparam int unsigned AddrW = $clog2(RING_DEPTH);
	localparam int unsigned ChW = fed_chan_w(MAX_CHANNELS);
	// Queue entry: sample, channel, write address, read address.
	localparam int unsigned QW = FED_SAMPLE_W + ChW + 2 * AddrW;

	logic [FED_NCH_W-1:0] num_channels_q;
	logic [FED_FRAMES_W-1:0] delay_frames_q;
	logic [FED_GAIN_W-1:0] feedback_gain_q;
	logic restart;

	logic clearing;
	logic queue_full;
	logic push;
	logic signed [FED_SAMPLE_W-1:0] push_sample;
	logic [ChW-1:0] push_chan;
	logic [AddrW-1:0] push_wa;
	logic [AddrW-1:0] push_ra;
	logic [QW-1:0] push_data;

	logic head_valid;
	logic head_pop;
	logic [QW-1:0] head_data;
	logic signed [FED_SAMPLE_W-1:0] head_sample;
	logic [ChW-1:0] head_chan;
	logic [AddrW-1:0] head_wa;
	logic [AddrW-1:0] head_ra;

	// Only writes to an existing register restart the frame positions.
	assign restart = cfg_we && ((cfg_index == FED_REG_NUM_CHANNELS)
		|| (cfg_index == FED_REG_DELAY_FRAMES) || (cfg_index == FED_REG_FEEDBACK_GAIN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q <= FED_RST_NUM_CHANNELS;
			delay_frames_q <= FED_RST_DELAY_FRAMES;
			feedback_gain_q <= FED_RST_FEEDBACK_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				FED_REG_NUM_CHANNELS: num_channels_q <= cfg_data[FED_NCH_W-1:0];
				FED_REG_DELAY_FRAMES: delay_frames_q <= cfg_data[FED_FRAMES_W-1:0];
				FED_REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data[FED_GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	fed_front #(
		.RING_DEPTH(RING_DEPTH),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.num_channels(num_channels_q),
		.delay_frames(delay_frames_q),
		.restart(restart),
		.clearing(clearing),
		.queue_full(queue_full),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.push(push),
		.push_sample(push_sample),
		.push_chan(push_chan),
		.push_wa(push_wa),
		.push_ra(push_ra)
	);

	assign push_data = {push_sample, push_chan, push_wa, push_ra};

	fed_queue #(
		.W(QW),
		.DEPTH(FED_QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(queue_full),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(head_pop)
	);

	assign {head_sample, head_chan, head_wa, head_ra} = head_data;

	fed_back #(
		.RING_DEPTH(RING_DEPTH),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.feedback_gain(feedback_gain_q),
		.clearing(clearing),
		.head_valid(head_valid),
		.head_pop(head_pop),
		.head_sample(head_sample),
		.head_chan(head_chan),
		.head_wa(head_wa),
		.head_ra(head_ra),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.channel_index(channel_index)
	);

endmodule
